// ===== hw/rtl/i2cees_pkg.sv =====
package i2cees_pkg;

  localparam int unsigned WriteDepth = 16;
  localparam int unsigned ReadDepth  = 16;
  localparam int unsigned SlotW      = $clog2(WriteDepth);
  localparam int unsigned CountW     = $clog2(WriteDepth + 1);
  localparam int unsigned RdCountW   = $clog2(ReadDepth + 1);
  localparam int unsigned RxIndexW   = 4;

  // Request function codes
  localparam logic [1:0] FuncLoad   = 2'd0;
  localparam logic [1:0] FuncBegin  = 2'd1;
  localparam logic [1:0] FuncStatus = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgDevAddr = 2'd0;
  localparam logic [1:0] CfgReadLen = 2'd1;

  // Bus engine status codes
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRepStart   = 8'h10;
  localparam logic [7:0] StAddrWAck   = 8'h18;
  localparam logic [7:0] StAddrWNack  = 8'h20;
  localparam logic [7:0] StDataWAck   = 8'h28;
  localparam logic [7:0] StDataWNack  = 8'h30;
  localparam logic [7:0] StAddrRAck   = 8'h40;
  localparam logic [7:0] StAddrRNack  = 8'h48;
  localparam logic [7:0] StDataRAck   = 8'h50;
  localparam logic [7:0] StDataRNack  = 8'h58;

  // Reported phase codes
  localparam logic [2:0] PhCodeIdle     = 3'd0;
  localparam logic [2:0] PhCodeAddr     = 3'd1;
  localparam logic [2:0] PhCodeWordHi   = 3'd2;
  localparam logic [2:0] PhCodeWordLo   = 3'd3;
  localparam logic [2:0] PhCodeRepStart = 3'd4;
  localparam logic [2:0] PhCodeRestart  = 3'd5;
  localparam logic [2:0] PhCodeData     = 3'd6;
  localparam logic [2:0] PhCodeDone     = 3'd7;

  typedef enum logic [7:0] {
    PhIdle     = 8'b0000_0001,
    PhAddr     = 8'b0000_0010,
    PhWordHi   = 8'b0000_0100,
    PhWordLo   = 8'b0000_1000,
    PhRepStart = 8'b0001_0000,
    PhRestart  = 8'b0010_0000,
    PhData     = 8'b0100_0000,
    PhDone     = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    ModeIdle  = 3'b001,
    ModeWrite = 3'b010,
    ModeRead  = 3'b100
  } mode_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [15:0] word_address;
    logic        is_read;
    logic [4:0]  write_count;
    logic [7:0]  write_byte;
    logic [3:0]  byte_slot;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic       ack_set;
    logic       ack_clear;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [3:0] rx_index;
    logic       done_res;
    logic [2:0] phase;
  } out_t;

  typedef struct packed {
    phase_e              phase;
    mode_e               mode;
    logic [15:0]         word_addr;
    logic [CountW-1:0]   write_total;
    logic [CountW-1:0]   write_index;
    logic [RdCountW-1:0] read_index;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [4:0] read_len;
  } cfg_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] c;
    unique case (ph)
      PhIdle:     c = PhCodeIdle;
      PhAddr:     c = PhCodeAddr;
      PhWordHi:   c = PhCodeWordHi;
      PhWordLo:   c = PhCodeWordLo;
      PhRepStart: c = PhCodeRepStart;
      PhRestart:  c = PhCodeRestart;
      PhData:     c = PhCodeData;
      PhDone:     c = PhCodeDone;
      default:    c = PhCodeIdle;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/i2cees_step.sv =====
module i2cees_step (
  input  i2cees_pkg::in_t        item_i,
  input  i2cees_pkg::seq_state_t st_i,
  input  i2cees_pkg::cfg_t       cfg_i,
  input  logic [7:0]             buf_rdata_i,
  output i2cees_pkg::seq_state_t st_o,
  output i2cees_pkg::out_t       res_o
);
  import i2cees_pkg::*;

  logic [RdCountW-1:0] rd_idx_sat;
  logic [RdCountW-1:0] rd_idx_inc;

  always_comb begin
    rd_idx_sat = (st_i.read_index >= RdCountW'(ReadDepth)) ?
                 RdCountW'(ReadDepth - 1) : st_i.read_index;
    rd_idx_inc = (st_i.read_index < RdCountW'(ReadDepth)) ?
                 st_i.read_index + RdCountW'(1) : st_i.read_index;
  end

  always_comb begin
    logic data_path;
    data_path = 1'b0;
    st_o  = st_i;
    res_o = '0;

    unique case (item_i.func)
      FuncLoad: ;
      FuncBegin: begin
        st_o.word_addr   = item_i.word_address;
        st_o.mode        = item_i.is_read ? ModeRead : ModeWrite;
        st_o.write_total = (item_i.write_count > 5'(WriteDepth)) ?
                           CountW'(WriteDepth) : CountW'(item_i.write_count);
        st_o.phase       = PhIdle;
        res_o.set_start  = 1'b1;
      end
      FuncStatus: begin
        unique case (item_i.status_code)
          StStart: begin
            st_o.write_index  = '0;
            res_o.tx_valid    = 1'b1;
            res_o.tx_byte     = cfg_i.dev_addr;
            res_o.clear_start = 1'b1;
            st_o.phase        = PhAddr;
          end
          StRepStart: begin
            st_o.read_index   = '0;
            res_o.tx_valid    = 1'b1;
            res_o.tx_byte     = cfg_i.dev_addr | 8'h01;
            res_o.clear_start = 1'b1;
            st_o.phase        = PhRestart;
          end
          StAddrWAck: begin
            if (st_i.phase == PhAddr) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = st_i.word_addr[15:8];
              st_o.phase     = PhWordHi;
            end
          end
          StDataWAck: begin
            priority if (st_i.phase == PhWordHi) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = st_i.word_addr[7:0];
              st_o.phase     = PhWordLo;
            end else if (st_i.mode == ModeRead) begin
              res_o.set_start = 1'b1;
              st_o.phase      = PhRepStart;
            end else begin
              data_path = 1'b1;
            end
          end
          StDataWNack: data_path = 1'b1;
          StAddrRAck: begin
            if (cfg_i.read_len == 5'd1) res_o.ack_clear = 1'b1;
            else res_o.ack_set = 1'b1;
          end
          StDataRAck: begin
            res_o.rx_valid  = 1'b1;
            res_o.rx_data   = item_i.rx_byte;
            res_o.rx_index  = rd_idx_sat[RxIndexW-1:0];
            st_o.read_index = rd_idx_inc;
            if (RdCountW'(rd_idx_inc) < RdCountW'(cfg_i.read_len)) begin
              res_o.ack_set = 1'b1;
              st_o.phase    = PhData;
            end else begin
              res_o.ack_clear = 1'b1;
              res_o.done_res  = 1'b1;
              st_o.phase      = PhDone;
            end
          end
          StDataRNack: begin
            res_o.rx_valid  = 1'b1;
            res_o.rx_data   = item_i.rx_byte;
            res_o.rx_index  = rd_idx_sat[RxIndexW-1:0];
            st_o.read_index = rd_idx_inc;
            res_o.set_stop  = 1'b1;
            res_o.done_res  = 1'b1;
            st_o.phase      = PhDone;
          end
          StAddrWNack, StAddrRNack: begin
            res_o.done_res = 1'b1;
            st_o.phase     = PhDone;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // Next buffered byte, else repeated start for a read, else stop
    if (data_path) begin
      priority if (st_i.write_index < st_i.write_total) begin
        res_o.tx_valid   = 1'b1;
        res_o.tx_byte    = buf_rdata_i;
        st_o.write_index = st_i.write_index + CountW'(1);
        st_o.phase       = PhData;
      end else if (cfg_i.read_len != 5'd0) begin
        res_o.set_start = 1'b1;
        st_o.phase      = PhRepStart;
      end else begin
        res_o.set_stop = 1'b1;
        res_o.done_res = 1'b1;
        st_o.phase     = PhDone;
      end
    end

    res_o.phase = phase_code(st_o.phase);
  end

endmodule

// ===== hw/rtl/i2c_eeprom_master_sequencer.sv =====
// Master-side sequencer for a random read or write of a serial EEPROM with a
// 16-bit word address, driven by the status codes of an I2C byte engine.
// Load write data with load requests, issue a begin request, then pass each
// engine status code in as a status request; every request yields exactly one
// result carrying the byte to send, start/stop/acknowledge controls, any
// received byte and the new phase. A request is taken every clock cycle while
// the output register is empty or being read out, and its result enters that
// register in the next cycle through the single decode stage before it.
// Configuration writes are taken at any time, but must only be issued while
// no request is in flight.
module i2c_eeprom_master_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2cees_pkg::in_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cees_pkg::out_t  out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import i2cees_pkg::*;

  seq_state_t st_q, st_d;
  cfg_t       cfg_q;
  out_t       res_d, out_q;
  logic       out_valid_q;
  logic [7:0] wbuf_q [WriteDepth];
  logic       in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  i2cees_step u_step (
    .item_i      (in_i),
    .st_i        (st_q),
    .cfg_i       (cfg_q),
    .buf_rdata_i (wbuf_q[st_q.write_index[SlotW-1:0]]),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= PhIdle;
      st_q.mode        <= ModeIdle;
      st_q.word_addr   <= '0;
      st_q.write_total <= '0;
      st_q.write_index <= '0;
      st_q.read_index  <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr <= 8'd160;
      cfg_q.read_len <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDevAddr: cfg_q.dev_addr <= cfg_data_i;
        CfgReadLen: cfg_q.read_len <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.func == FuncLoad) begin
      wbuf_q[in_i.byte_slot[SlotW-1:0]] <= in_i.write_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

endmodule

// ===== hw/rtl/i2cees_checker.sv =====
module i2cees_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input i2cees_pkg::out_t out_o,
  input logic             out_valid_o,
  input logic             out_ready_i
);
  import i2cees_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // Accepted request shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("request refused while the output register is free");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.done_res |-> out_o.phase == PhCodeDone)
    else $error("done flagged outside the done phase");

  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.rx_valid |-> out_o.rx_data == 8'd0 && out_o.rx_index == 4'd0)
    else $error("received byte fields set without a received byte");

endmodule

bind i2c_eeprom_master_sequencer i2cees_checker u_i2cees_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_o       (out_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

// ===== tb/eeprom_seq_checker.sv =====
`timescale 1ns / 100ps

module eeprom_seq_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  i2cees_pkg::in_t   in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  i2cees_pkg::out_t  out_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output int                fails_o,
  output int                pending_o
);
  import i2cees_pkg::*;

  // own copy of the configuration and of the sequencer state
  logic [7:0]  dev_addr_q;
  logic [4:0]  read_len_q;
  logic [2:0]  phase_q;
  mode_e       mode_q;
  logic [15:0] word_addr_q;
  logic [4:0]  wr_total_q;
  logic [4:0]  wr_idx_q;
  logic [4:0]  rd_idx_q;
  logic [7:0]  wr_buf_q [WriteDepth];

  out_t expected_controls [$];
  out_t want;
  logic bad;
  int   errors;

  function automatic out_t next_controls(in_t r);
    out_t o;
    logic tail;
    o = '0;
    tail = 1'b0;
    case (r.func)
      FuncLoad: begin
        wr_buf_q[r.byte_slot] = r.write_byte;
      end
      FuncBegin: begin
        word_addr_q = r.word_address;
        mode_q = r.is_read ? ModeRead : ModeWrite;
        wr_total_q = (r.write_count > WriteDepth) ? 5'(WriteDepth) : r.write_count;
        phase_q = PhCodeIdle;
        o.set_start = 1'b1;
      end
      FuncStatus: begin
        case (r.status_code)
          StStart: begin
            wr_idx_q = '0;
            o.tx_valid = 1'b1;
            o.tx_byte = dev_addr_q;
            o.clear_start = 1'b1;
            phase_q = PhCodeAddr;
          end
          StRepStart: begin
            rd_idx_q = '0;
            o.tx_valid = 1'b1;
            o.tx_byte = dev_addr_q | 8'h01;
            o.clear_start = 1'b1;
            phase_q = PhCodeRestart;
          end
          StAddrWAck: begin
            if (phase_q == PhCodeAddr) begin
              o.tx_valid = 1'b1;
              o.tx_byte = word_addr_q[15:8];
              phase_q = PhCodeWordHi;
            end
          end
          StDataWAck: begin
            if (phase_q == PhCodeWordHi) begin
              o.tx_valid = 1'b1;
              o.tx_byte = word_addr_q[7:0];
              phase_q = PhCodeWordLo;
            end else if (mode_q == ModeRead) begin
              o.set_start = 1'b1;
              phase_q = PhCodeRepStart;
            end else begin
              tail = 1'b1;
            end
          end
          StDataWNack: tail = 1'b1;
          StAddrRAck: begin
            if (read_len_q == 5'd1) o.ack_clear = 1'b1;
            else o.ack_set = 1'b1;
          end
          StDataRAck, StDataRNack: begin
            o.rx_valid = 1'b1;
            o.rx_data = r.rx_byte;
            // hold the index at the last buffer position once it runs over
            o.rx_index = (rd_idx_q >= ReadDepth) ? 4'(ReadDepth - 1) : rd_idx_q[3:0];
            if (rd_idx_q < ReadDepth) rd_idx_q = rd_idx_q + 5'd1;
            if (r.status_code == StDataRNack) begin
              o.set_stop = 1'b1;
              o.done_res = 1'b1;
              phase_q = PhCodeDone;
            end else if (rd_idx_q < read_len_q) begin
              o.ack_set = 1'b1;
              phase_q = PhCodeData;
            end else begin
              o.ack_clear = 1'b1;
              o.done_res = 1'b1;
              phase_q = PhCodeDone;
            end
          end
          StAddrWNack, StAddrRNack: begin
            o.done_res = 1'b1;
            phase_q = PhCodeDone;
          end
          default: ;
        endcase
        // next data byte, else turn round for the read, else close with a stop
        if (tail) begin
          if (wr_idx_q < wr_total_q) begin
            o.tx_valid = 1'b1;
            o.tx_byte = wr_buf_q[wr_idx_q[3:0]];
            wr_idx_q = wr_idx_q + 5'd1;
            phase_q = PhCodeData;
          end else if (read_len_q != '0) begin
            o.set_start = 1'b1;
            phase_q = PhCodeRepStart;
          end else begin
            o.set_stop = 1'b1;
            o.done_res = 1'b1;
            phase_q = PhCodeDone;
          end
        end
      end
      default: ;
    endcase
    o.phase = phase_q;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  = 8'd160;
      read_len_q  = '0;
      phase_q     = PhCodeIdle;
      mode_q      = ModeIdle;
      word_addr_q = '0;
      wr_total_q  = '0;
      wr_idx_q    = '0;
      rd_idx_q    = '0;
      expected_controls.delete();
      errors      = 0;
      fails_o    <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDevAddr: dev_addr_q = cfg_data_i;
          CfgReadLen: read_len_q = cfg_data_i[4:0];
          default: ;
        endcase
      end
      // retire before predicting: a request never answers at its own edge
      if (out_valid_i && out_ready_i) begin
        if (expected_controls.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, out_i);
          errors++;
        end else begin
          want = expected_controls.pop_front();
          bad = 1'b0;
          check_field("tx_valid", want.tx_valid, out_i.tx_valid);
          check_field("tx_byte", want.tx_byte, out_i.tx_byte);
          check_field("set_start", want.set_start, out_i.set_start);
          check_field("clear_start", want.clear_start, out_i.clear_start);
          check_field("set_stop", want.set_stop, out_i.set_stop);
          check_field("ack_set", want.ack_set, out_i.ack_set);
          check_field("ack_clear", want.ack_clear, out_i.ack_clear);
          check_field("rx_valid", want.rx_valid, out_i.rx_valid);
          check_field("rx_data", want.rx_data, out_i.rx_data);
          check_field("rx_index", want.rx_index, out_i.rx_index);
          check_field("done_res", want.done_res, out_i.done_res);
          check_field("phase", want.phase, out_i.phase);
          if (bad) errors++;
        end
      end
      if (in_valid_i && in_ready_i) expected_controls.push_back(next_controls(in_i));
      pending_o <= expected_controls.size();
      fails_o   <= errors;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import i2cees_pkg::*;

  localparam logic [1:0] FuncSpare = 2'd3;
  localparam int StallLimit = 1000;
  localparam int HoldCycles = 48;

  typedef enum {MidNone, MidHold, MidPause} mid_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_req;
  logic        out_valid;
  logic        out_ready;
  out_t        out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fails;
  int          pending;

  logic [WriteDepth-1:0] written = '0;
  logic [4:0]  read_len = '0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          sent = 0;

  logic [7:0] known_codes [10] = '{StStart, StRepStart, StAddrWAck, StAddrWNack, StDataWAck,
                                   StDataWNack, StAddrRAck, StAddrRNack, StDataRAck,
                                   StDataRNack};

  i2c_eeprom_master_sequencer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  eeprom_seq_checker seq_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_i       (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random back-pressure, plus one long hold-off on demand
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic in_t rand_req();
    in_t r;
    r.func         = 2'($urandom);
    r.status_code  = 8'($urandom);
    r.rx_byte      = 8'($urandom);
    r.word_address = 16'($urandom);
    r.is_read      = 1'($urandom);
    r.write_count  = 5'($urandom);
    r.write_byte   = 8'($urandom);
    r.byte_slot    = 4'($urandom);
    return r;
  endfunction

  // a write count that only ever reaches buffer slots already loaded
  function automatic logic [4:0] safe_count();
    int lead;
    lead = 0;
    while (lead < WriteDepth && written[lead]) lead++;
    if (lead == WriteDepth) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, lead));
  endfunction

  task automatic offer(input in_t item);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_req   <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (item.func == FuncLoad) written[item.byte_slot] = 1'b1;
    if (item.func != FuncSpare) sent++;
  endtask

  task automatic load_byte(input logic [3:0] slot, input logic [7:0] data);
    in_t r;
    r = rand_req();
    r.func = FuncLoad;
    r.byte_slot = slot;
    r.write_byte = data;
    offer(r);
  endtask

  task automatic begin_xfer(input logic [15:0] addr, input logic rd, input logic [4:0] count);
    in_t r;
    r = rand_req();
    r.func = FuncBegin;
    r.word_address = addr;
    r.is_read = rd;
    r.write_count = count;
    offer(r);
  endtask

  task automatic status(input logic [7:0] code, input logic [7:0] rxb);
    in_t r;
    r = rand_req();
    r.func = FuncStatus;
    r.status_code = code;
    r.rx_byte = rxb;
    offer(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dev, input logic [4:0] len);
    drain();
    repeat (4) @(posedge clk);
    cfg_index <= CfgDevAddr;
    cfg_data  <= dev;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CfgReadLen;
    cfg_data  <= {3'b000, len};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    read_len = len;
  endtask

  task automatic write_xfer();
    int n;
    logic [4:0] count;
    n = ($urandom_range(0, 3) == 0) ? WriteDepth : $urandom_range(0, WriteDepth);
    for (int s = 0; s < n; s++) load_byte(4'(s), 8'($urandom));
    count = 5'(n);
    if (n == WriteDepth && $urandom_range(0, 1) == 1) count = 5'($urandom_range(WriteDepth, 31));
    begin_xfer(16'($urandom), 1'b0, count);
    status(StStart, 8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      status(StAddrWNack, 8'($urandom));
      return;
    end
    status(StAddrWAck, 8'($urandom));
    status(StDataWAck, 8'($urandom));
    for (int k = 0; k <= n; k++)
      status(($urandom_range(0, 7) == 0) ? StDataWNack : StDataWAck, 8'($urandom));
  endtask

  task automatic read_xfer();
    int n;
    begin_xfer(16'($urandom), 1'b1, ($urandom_range(0, 3) == 0) ? safe_count() : 5'd0);
    status(StStart, 8'($urandom));
    status(StAddrWAck, 8'($urandom));
    status(StDataWAck, 8'($urandom));
    status(StDataWAck, 8'($urandom));
    status(StRepStart, 8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      status(StAddrRNack, 8'($urandom));
      return;
    end
    status(StAddrRAck, 8'($urandom));
    n = read_len;
    // now and then run past the requested length
    if ($urandom_range(0, 5) == 0) n += $urandom_range(1, 4);
    for (int k = 0; k < n; k++)
      status((k == n - 1 && $urandom_range(0, 3) != 0) ? StDataRNack : StDataRAck,
             8'($urandom));
  endtask

  task automatic noise();
    in_t r;
    r = rand_req();
    case ($urandom_range(0, 9))
      0: r.func = FuncLoad;
      1: begin
        r.func = FuncBegin;
        r.write_count = safe_count();
      end
      2: r.func = FuncSpare;
      3, 4: r.func = FuncStatus;
      default: begin
        r.func = FuncStatus;
        r.status_code = known_codes[$urandom_range(0, 9)];
      end
    endcase
    offer(r);
  endtask

  task automatic run_random(input int n, input mid_e mid);
    int stop_at;
    int half;
    stop_at = sent + n;
    half = sent + n / 2;
    while (sent < stop_at) begin
      if (mid != MidNone && sent >= half) begin
        if (mid == MidHold) hold_req = 1'b1;
        else drain();
        mid = MidNone;
      end
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 5)) noise();
        2, 3, 4, 5: write_xfer();
        default: read_xfer();
      endcase
    end
  endtask

  task automatic directed();
    in_t r;
    load_byte(4'd0, 8'h00);
    load_byte(4'd15, 8'hFF);
    load_byte(4'd1, 8'hA5);
    r = '1;
    r.func = FuncSpare;
    offer(r);
    begin_xfer(16'hFFFF, 1'b0, 5'd2);
    status(StStart, 8'h00);
    status(StAddrWAck, 8'h00);
    status(StDataWAck, 8'h00);
    status(StDataWAck, 8'h00);
    status(StDataWNack, 8'h00);
    status(StDataWNack, 8'h00);
    status(8'h77, 8'h00);
    status(StAddrWNack, 8'h00);
    begin_xfer(16'h0000, 1'b1, 5'd0);
    status(StStart, 8'hFF);
    status(StAddrRNack, 8'hFF);
    status(StAddrWAck, 8'hFF);
    status(StRepStart, 8'hFF);
    status(StAddrRAck, 8'hFF);
    status(StDataRAck, 8'hFF);
    status(StDataRNack, 8'h00);
    status(StDataWAck, 8'h00);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    run_random(270, MidNone);
    set_config(8'h00, 5'd16);
    run_random(270, MidHold);
    set_config(8'hFF, 5'd1);
    calm = 1'b1;
    run_random(270, MidNone);
    calm = 1'b0;
    set_config(8'($urandom), 5'd0);
    run_random(270, MidPause);
    set_config(8'($urandom), 5'($urandom_range(2, 15)));
    run_random(270, MidNone);
    set_config(8'($urandom), 5'd16);
    run_random(270, MidNone);

    drain();
    repeat (4) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
